>>> rtl/uxe_pkg.sv
// Shared types, character constants and lookup functions for the
// UTF-8 XML character escaper. No dependencies.
package uxe_pkg;

	localparam int CP_W  = 21;
	localparam int DIG_N = 7;
	localparam int BCD_W = 4 * DIG_N;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		K_PASS,
		K_QUOT,
		K_APOS,
		K_AMP,
		K_LT,
		K_GT,
		K_HEX,
		K_DEC
	} kind_t;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_LESS  = 8'h3c;
	localparam logic [7:0] CH_GREAT = 8'h3e;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7e;
	localparam logic [7:0] LEAD2    = 8'hc0;
	localparam logic [7:0] LEAD3    = 8'he0;
	localparam logic [7:0] LEAD4    = 8'hf0;

	localparam logic [47:0] STR_QUOT = "&quot;";
	localparam logic [47:0] STR_APOS = "&apos;";
	localparam logic [47:0] STR_AMP  = {"&amp;", 8'h00};
	localparam logic [47:0] STR_LT   = {"&lt;", 16'h0000};
	localparam logic [47:0] STR_GT   = {"&gt;", 16'h0000};

	function automatic kind_t classify(input logic [7:0] c);
		kind_t k;
		if (c == CH_QUOTE) begin
			k = K_QUOT;
		end else if (c == CH_APOS) begin
			k = K_APOS;
		end else if (c == CH_AMP) begin
			k = K_AMP;
		end else if (c == CH_LESS) begin
			k = K_LT;
		end else if (c == CH_GREAT) begin
			k = K_GT;
		end else if ((c >= PRINT_LO && c <= PRINT_HI) || c == CH_TAB || c == CH_LF
				|| c == CH_CR) begin
			k = K_PASS;
		end else begin
			k = K_HEX;
		end
		return k;
	endfunction

	function automatic logic [3:0] kind_len(input kind_t k, input logic [7:0] c);
		logic [3:0] n;
		unique case (k)
			K_PASS:        n = 4'd1;
			K_QUOT, K_APOS: n = 4'd6;
			K_AMP:         n = 4'd5;
			K_LT, K_GT:    n = 4'd4;
			K_HEX:         n = (c[7:4] != 4'd0) ? 4'd6 : 4'd5;
			default:       n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] ent_char(input kind_t k, input logic [2:0] i);
		logic [47:0] s;
		unique case (k)
			K_QUOT:  s = STR_QUOT;
			K_APOS:  s = STR_APOS;
			K_AMP:   s = STR_AMP;
			K_LT:    s = STR_LT;
			K_GT:    s = STR_GT;
			default: s = '0;
		endcase
		return s[8 * (5 - int'(i)) +: 8];
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'd0, d};
		end else begin
			r = CH_LA + {4'd0, d - 4'd10};
		end
		return r;
	endfunction

endpackage

>>> rtl/utf8_xml_character_escaper_core.sv
// Top level of the UTF-8 XML character escaper: decoder state, sequencer
// and output register. Depends on uxe_pkg and uxe_bcd.
//
// One byte is taken when the block is idle. Lead and middle continuation
// bytes give nothing and leave the block idle. A byte escaped on its own
// gives 1 to 6 output characters. A byte that completes a multi-byte
// sequence starts the shift-and-add-3 converter (21 steps of one code point
// bit each, then a registered done flag) and then gives 4 to 10 output
// characters. Output characters are loaded one per cycle unless the output
// stalls; in_stall stays high from an accepted byte that gives output until
// its last character is loaded into the output register.
module utf8_xml_character_escaper_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       string_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_last
);
	import uxe_pkg::*;

	state_t           state_q, state_d;
	kind_t            kind_q, kind_in;
	logic [7:0]       byte_q;
	logic [3:0]       idx_q;
	logic [3:0]       len_q;
	logic [1:0]       left_q;
	logic [CP_W-1:0]  cp_q, cp_new;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             run_last_q;
	logic             acc, take, emit_ld, bcd_start, bcd_done, lead, last_cont;
	logic [BCD_W-1:0] digits;
	logic [3:0]       ndig;
	logic [3:0]       dsel;
	logic [7:0]       ch;

	uxe_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (cp_new),
		.done   (bcd_done),
		.digits (digits)
	);

	assign acc       = in_valid && !in_stall;
	assign take      = !out_valid_q || !out_stall;
	assign lead      = (left_q == 2'd0) && (in_byte >= LEAD2);
	assign last_cont = (left_q == 2'd1);
	assign kind_in   = classify(in_byte);

	always_comb begin
		unique case (left_q)
			2'd3:    cp_new = cp_q | (CP_W'(in_byte[5:0]) << 12);
			2'd2:    cp_new = cp_q | (CP_W'(in_byte[5:0]) << 6);
			default: cp_new = cp_q | CP_W'(in_byte[5:0]);
		endcase
	end

	always_comb begin
		priority if (digits[27:24] != 4'd0) ndig = 4'd7;
		else if (digits[23:20] != 4'd0) ndig = 4'd6;
		else if (digits[19:16] != 4'd0) ndig = 4'd5;
		else if (digits[15:12] != 4'd0) ndig = 4'd4;
		else if (digits[11:8] != 4'd0) ndig = 4'd3;
		else if (digits[7:4] != 4'd0) ndig = 4'd2;
		else ndig = 4'd1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && left_q == 2'd0 && !lead) begin
					state_d = ST_EMIT;
				end else if (acc && last_cont) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (bcd_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (take && idx_q == len_q - 4'd1) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		bcd_start = (state_q == ST_IDLE) && in_valid && last_cont;
		emit_ld   = (state_q == ST_EMIT) && take;
	end

	assign dsel = len_q - 4'd2 - idx_q;

	always_comb begin
		ch = CH_SEMI;
		unique case (kind_q)
			K_PASS: ch = byte_q;
			K_HEX: begin
				unique case (idx_q)
					4'd0: ch = CH_AMP;
					4'd1: ch = CH_HASH;
					4'd2: ch = CH_X;
					4'd3: ch = (byte_q[7:4] != 4'd0) ? hex_char(byte_q[7:4])
						: hex_char(byte_q[3:0]);
					4'd4: ch = (byte_q[7:4] != 4'd0) ? hex_char(byte_q[3:0]) : CH_SEMI;
					default: ch = CH_SEMI;
				endcase
			end
			K_DEC: begin
				if (idx_q == 4'd0) begin
					ch = CH_AMP;
				end else if (idx_q == 4'd1) begin
					ch = CH_HASH;
				end else if (idx_q == len_q - 4'd1) begin
					ch = CH_SEMI;
				end else begin
					ch = CH_ZERO + {4'd0, digits[4*dsel[2:0] +: 4]};
				end
			end
			default: ch = ent_char(kind_q, idx_q[2:0]);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_q      <= 2'd0;
			cp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				if (left_q == 2'd0) begin
					if (in_byte >= LEAD4) begin
						left_q <= 2'd3;
						cp_q   <= CP_W'(in_byte[2:0]) << 18;
					end else if (in_byte >= LEAD3) begin
						left_q <= 2'd2;
						cp_q   <= CP_W'(in_byte[3:0]) << 12;
					end else if (in_byte >= LEAD2) begin
						left_q <= 2'd1;
						cp_q   <= CP_W'(in_byte[4:0]) << 6;
					end
				end else begin
					left_q <= left_q - 2'd1;
					cp_q   <= last_cont ? '0 : cp_new;
				end
				if (string_end) begin
					left_q <= 2'd0;
					cp_q   <= '0;
				end
			end
			if (emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byte_q <= in_byte;
			idx_q  <= 4'd0;
			if (last_cont) begin
				kind_q <= K_DEC;
			end else begin
				kind_q <= kind_in;
				len_q  <= kind_len(kind_in, in_byte);
			end
		end
		if (state_q == ST_CONV && bcd_done) begin
			len_q <= ndig + 4'd3;
		end
		if (emit_ld) begin
			out_char_q <= ch;
			run_last_q <= (idx_q == len_q - 4'd1);
			idx_q      <= idx_q + 4'd1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_last  = run_last_q;

endmodule

>>> rtl/uxe_bcd.sv
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
// Depends on uxe_pkg.
module uxe_bcd (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [uxe_pkg::CP_W-1:0]  value,
	output logic                      done,
	output logic [uxe_pkg::BCD_W-1:0] digits
);
	import uxe_pkg::*;

	localparam int CNT_W = $clog2(CP_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CP_W-1:0]  bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		for (int i = 0; i < DIG_N; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[CP_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[CP_W-1]};
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule

>>> rtl/uxe_checker.sv
// Port-level checks for the UTF-8 XML character escaper, bound to the top
// level. Depends on utf8_xml_character_escaper_core.
module uxe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic       run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(run_last))
		else $error("stalled output item changed");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last && !out_stall |=> out_valid)
		else $error("gap inside a character run");

	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> in_stall)
		else $error("input taken while a run is unfinished");

	a_no_take_mid: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !(out_valid && !run_last && $past(out_valid && !run_last)))
		else $error("input accepted in the middle of a run");

endmodule

bind utf8_xml_character_escaper_core uxe_checker u_uxe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_char  (out_char),
	.run_last  (run_last)
);
